FILE: rtl/encoder_frame_crc8_checker_core_macros.svh
// Assertion macros for the encoder frame CRC-8 checker RTL.
// Each macro expects signals clk and arst_n in the enclosing module.
`ifndef ENCODER_FRAME_CRC8_CHECKER_CORE_MACROS_SVH
`define ENCODER_FRAME_CRC8_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EFCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define EFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/efcc_pkg.sv
// ----------------------------------------------------------------------------
// efcc_pkg
// Types and constants for the encoder frame CRC-8 checker.
// ----------------------------------------------------------------------------
package efcc_pkg;

	// Register indexes on the configuration port
	localparam logic CFG_CRC_POLYNOMIAL = 1'b0;
	localparam logic CFG_LOW_BYTE_MASK  = 1'b1;

	// Register reset values
	localparam logic [7:0] POLY_RESET = 8'h97;
	localparam logic [7:0] MASK_RESET = 8'hC1;

	// Byte positions within a frame
	localparam logic [2:0] POS_HDR0  = 3'd0;
	localparam logic [2:0] POS_HDR1  = 3'd1;
	localparam logic [2:0] POS_POS_HI = 3'd2;
	localparam logic [2:0] POS_POS_MID = 3'd3;
	localparam logic [2:0] POS_POS_LO = 3'd4;
	localparam logic [2:0] POS_LAST  = 3'd6;
	localparam logic [2:0] POS_WAIT  = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} req_t;

	typedef struct packed {
		logic        crc_ok;
		logic [23:0] position_word;
		logic [7:0]  computed_check;
		logic [7:0]  error_count;
	} rsp_t;

	typedef struct packed {
		logic [7:0] crc_polynomial;
		logic [7:0] low_byte_mask;
	} cfg_regs_t;

endpackage

FILE: rtl/encoder_frame_crc8_checker_core.sv
// A check byte's result passes the byte and result registers to rsp.
// Throughput: one byte per cycle; the byte register and result register both
// advance in the same cycle, so a stall only occurs while the result waits.
// Bytes that give no result never wait on the consumer.
// Reset: clears the frame state, the error count and sets the registers to
// polynomial 0x97 and mask 0xC1; the checker then waits for a start flag.
// ----------------------------------------------------------------------------
// encoder_frame_crc8_checker_core
// CRC-8 check of 7-byte absolute-encoder frames with position word output.
// ----------------------------------------------------------------------------
module encoder_frame_crc8_checker_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           req_valid,
	output logic           req_ready,
	input  efcc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output efcc_pkg::rsp_t rsp
);

	efcc_pkg::cfg_regs_t cfg_q;
	logic                res_valid;
	logic                res_ready;
	efcc_pkg::rsp_t      res;

	// Write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_polynomial <= efcc_pkg::POLY_RESET;
			cfg_q.low_byte_mask  <= efcc_pkg::MASK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efcc_pkg::CFG_CRC_POLYNOMIAL: cfg_q.crc_polynomial <= cfg_data;
				efcc_pkg::CFG_LOW_BYTE_MASK:  cfg_q.low_byte_mask  <= cfg_data;
				default: ;
			endcase
		end
	end

	efcc_frame_ctl u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	efcc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

FILE: rtl/efcc_crc8_step.sv
// ----------------------------------------------------------------------------
// efcc_crc8_step
// One byte of MSB-first CRC-8 update, eight shift/XOR steps in logic.
// ----------------------------------------------------------------------------
module efcc_crc8_step (
	input  logic [7:0] crc,
	input  logic [7:0] data_byte,
	input  logic [7:0] poly,
	output logic [7:0] crc_next
);

	// Shift the combined byte out MSB first, folding in the polynomial
	always_comb begin
		logic [7:0] v;
		v = crc ^ data_byte;
		for (int b = 0; b < 8; b++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		crc_next = v;
	end

endmodule

FILE: rtl/efcc_frame_ctl.sv
// ----------------------------------------------------------------------------
// efcc_frame_ctl
// Input register, frame position tracking, CRC and position capture.
// ----------------------------------------------------------------------------
`include "encoder_frame_crc8_checker_core_macros.svh"

module efcc_frame_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  efcc_pkg::req_t      req,
	input  efcc_pkg::cfg_regs_t cfg,
	output logic                res_valid,
	input  logic                res_ready,
	output efcc_pkg::rsp_t      res
);

	logic           valid_s1;
	efcc_pkg::req_t req_s1;
	logic [2:0]     pos_q;
	logic [7:0]     crc_q;
	logic [23:0]    cap_q;
	logic [7:0]     fails_q;
	logic [7:0]     crc_next;
	logic           advance;
	logic           crc_match;

	efcc_crc8_step u_crc (
		.crc      (crc_q),
		.data_byte(req_s1.data_byte),
		.poly     (cfg.crc_polynomial),
		.crc_next (crc_next)
	);

	// Result on the check byte of a frame that is still open
	assign res_valid = valid_s1 && !req_s1.frame_start && (pos_q == efcc_pkg::POS_LAST);
	assign advance   = valid_s1 && (!res_valid || res_ready);
	assign req_ready = !valid_s1 || advance;
	assign crc_match = (req_s1.data_byte == crc_q);

	// Build the result from the captured state
	always_comb begin
		res.crc_ok         = crc_match;
		res.position_word  = cap_q;
		res.computed_check = crc_q;
		res.error_count    = fails_q + {7'd0, !crc_match};
	end

	// Hold the accepted request until it is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Advance the frame state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= efcc_pkg::POS_WAIT;
			crc_q   <= 8'd0;
			cap_q   <= 24'd0;
			fails_q <= 8'd0;
		end else if (advance) begin
			priority if (req_s1.frame_start) begin
				crc_q <= 8'd0;
				cap_q <= 24'd0;
				pos_q <= efcc_pkg::POS_HDR1;
			end else if (pos_q == efcc_pkg::POS_WAIT || pos_q == efcc_pkg::POS_HDR0) begin
				pos_q <= efcc_pkg::POS_WAIT;
			end else if (pos_q == efcc_pkg::POS_LAST) begin
				if (!crc_match) begin
					fails_q <= fails_q + 8'd1;
				end
				pos_q <= efcc_pkg::POS_WAIT;
			end else begin
				if (pos_q != efcc_pkg::POS_HDR1) begin
					crc_q <= crc_next;
				end
				if (pos_q == efcc_pkg::POS_POS_HI) begin
					cap_q[23:16] <= req_s1.data_byte;
				end
				if (pos_q == efcc_pkg::POS_POS_MID) begin
					cap_q[15:8] <= req_s1.data_byte;
				end
				if (pos_q == efcc_pkg::POS_POS_LO) begin
					cap_q[7:0] <= req_s1.data_byte & cfg.low_byte_mask;
				end
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	`EFCC_ASSERT_SAME(a_no_pos_zero, 1'b1, pos_q != efcc_pkg::POS_HDR0, "frame position reached byte 0")
	`EFCC_ASSERT_NEXT(a_wait_after_result, res_valid && res_ready, pos_q == efcc_pkg::POS_WAIT, "frame not closed after result")
	`EFCC_ASSERT_NEXT(a_fail_count, res_valid && res_ready && !crc_match, fails_q == 8'($past(fails_q) + 8'd1), "error count not advanced on failed frame")
	`EFCC_ASSERT_NEXT(a_stall_holds, valid_s1 && !advance, valid_s1 && $stable(req_s1), "stalled byte lost")

endmodule

FILE: rtl/efcc_out_reg.sv
// ----------------------------------------------------------------------------
// efcc_out_reg
// Result register that separates the frame logic from the consumer.
// ----------------------------------------------------------------------------
module efcc_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	output logic           res_ready,
	input  efcc_pkg::rsp_t res,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output efcc_pkg::rsp_t rsp
);

	logic           valid_q;
	efcc_pkg::rsp_t rsp_q;

	// Take a new result when empty or when the held one leaves
	assign res_ready = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

endmodule

FILE: tb/sv/encoder_frame_crc8_checker_core_tb.sv
// ----------------------------------------------------------------------------
// encoder_frame_crc8_checker_core_tb
// Drives encoder frame bytes into the CRC-8 checker and compares each frame
// result with a local model. The model tracks the byte position, CRC,
// position word, failed-frame count, polynomial and mask. The test runs
// directed frames first, then random well-formed, broken and noise traffic
// under several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module encoder_frame_crc8_checker_core_tb;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic           cfg_index = efcc_pkg::CFG_CRC_POLYNOMIAL;
	logic [7:0]     cfg_data = 8'h00;
	logic           req_valid = 1'b0;
	logic           req_ready;
	efcc_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	efcc_pkg::rsp_t rsp;

	// Model state and register copies
	logic [2:0]  frame_pos = efcc_pkg::POS_WAIT;
	logic [7:0]  crc_acc = 8'h00;
	logic [23:0] pos_capture = 24'h0;
	logic [7:0]  frames_failed = 8'h00;
	logic [7:0]  poly_setting = efcc_pkg::POLY_RESET;
	logic [7:0]  mask_setting = efcc_pkg::MASK_RESET;

	efcc_pkg::rsp_t frame_reports[$];
	int unsigned    mismatches = 0;
	int unsigned    send_idle_pct = 0;
	int unsigned    recv_stall_pct = 0;

	encoder_frame_crc8_checker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop if the run hangs
	initial begin
		#12000000;
		$display("simulation failed");
		$finish;
	end

	// MSB-first CRC-8 update of one byte
	function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d,
			input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ d;
		for (int b = 0; b < 8; b++) begin
			if (v[7]) begin
				v = (v << 1) ^ poly;
			end else begin
				v = v << 1;
			end
		end
		return v;
	endfunction

	// Advance the model by one accepted request; queue the frame report on the check byte
	task automatic predict_byte(input efcc_pkg::req_t item);
		efcc_pkg::rsp_t report;
		logic [7:0] d;
		d = item.data_byte;
		if (item.frame_start) begin
			crc_acc = 8'h00;
			pos_capture = 24'h0;
			frame_pos = efcc_pkg::POS_HDR1;
		end else if (frame_pos == efcc_pkg::POS_WAIT || frame_pos == efcc_pkg::POS_HDR0) begin
			frame_pos = efcc_pkg::POS_WAIT;
		end else if (frame_pos != efcc_pkg::POS_LAST) begin
			if (frame_pos >= efcc_pkg::POS_POS_HI) begin
				crc_acc = crc8_next(crc_acc, d, poly_setting);
				case (frame_pos)
					efcc_pkg::POS_POS_HI: pos_capture[23:16] = d;
					efcc_pkg::POS_POS_MID: pos_capture[15:8] = d;
					efcc_pkg::POS_POS_LO: pos_capture[7:0] = d & mask_setting;
					default: ;
				endcase
			end
			frame_pos = frame_pos + 3'd1;
		end else begin
			report.crc_ok = (d == crc_acc);
			if (!report.crc_ok)
				frames_failed = frames_failed + 8'd1;
			report.position_word = pos_capture;
			report.computed_check = crc_acc;
			report.error_count = frames_failed;
			frame_reports.push_back(report);
			frame_pos = efcc_pkg::POS_WAIT;
		end
	endtask

	// Send one request, with a random gap ahead of it
	task automatic send_byte(input logic [7:0] d, input logic start);
		efcc_pkg::req_t item;
		item.data_byte = d;
		item.frame_start = start;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predict_byte(item);
	endtask

	// Write one register once all reports are in and the pipeline has settled
	task automatic write_reg(input logic idx, input logic [7:0] val);
		req_valid <= 1'b0;
		while (frame_reports.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == efcc_pkg::CFG_CRC_POLYNOMIAL)
			poly_setting = val;
		else
			mask_setting = val;
	endtask

	// Send a whole frame; a good frame carries the CRC under the current polynomial
	task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
			input logic [31:0] body, input logic good, input logic [7:0] bad_flip);
		logic [7:0] crc;
		crc = 8'h00;
		for (int i = 3; i >= 0; i--)
			crc = crc8_next(crc, body[i*8 +: 8], poly_setting);
		send_byte(h0, 1'b1);
		send_byte(h1, 1'b0);
		for (int i = 3; i >= 0; i--)
			send_byte(body[i*8 +: 8], 1'b0);
		send_byte(good ? crc : crc ^ bad_flip, 1'b0);
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(15);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// Check each accepted result against the oldest queued report
	always @(posedge clk) begin
		efcc_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (frame_reports.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, rsp);
				mismatches++;
			end else begin
				want = frame_reports.pop_front();
				if (rsp.crc_ok !== want.crc_ok) begin
					$display("%0t: crc_ok expected %0d actual %0d",
						$time, want.crc_ok, rsp.crc_ok);
					mismatches++;
				end
				if (rsp.position_word !== want.position_word) begin
					$display("%0t: position_word expected %h actual %h",
						$time, want.position_word, rsp.position_word);
					mismatches++;
				end
				if (rsp.computed_check !== want.computed_check) begin
					$display("%0t: computed_check expected %h actual %h",
						$time, want.computed_check, rsp.computed_check);
					mismatches++;
				end
				if (rsp.error_count !== want.error_count) begin
					$display("%0t: error_count expected %0d actual %0d",
						$time, want.error_count, rsp.error_count);
					mismatches++;
				end
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// A byte with no start flag before any frame must be dropped
	task automatic test_idle_bytes_before_start();
		send_byte(8'h00, 1'b0);
	endtask

	// All-ones body under reset registers, correct check byte
	task automatic test_frame_extremes();
		send_frame(8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b1, 8'h00);
	endtask

	// Zero body with a wrong check byte, then a stray byte after the frame
	task automatic test_failed_frame();
		send_frame(8'h00, 8'hFF, 32'h0000_0000, 1'b0, 8'h01);
		send_byte(8'hAA, 1'b0);
	endtask

	// Restart mid-frame, then change both registers while the new frame is open
	task automatic test_restart_and_live_config();
		send_byte(8'h5A, 1'b1);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'hC3, 1'b1);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hA5, 1'b0);
		write_reg(efcc_pkg::CFG_CRC_POLYNOMIAL, 8'h31);
		send_byte(8'h96, 1'b0);
		send_byte(8'hF7, 1'b0);
		write_reg(efcc_pkg::CFG_LOW_BYTE_MASK, 8'h0F);
		send_byte(8'h08, 1'b0);
		send_byte(crc_acc, 1'b0);
	endtask

	// Mostly good and bad frames, plus truncated frames, noise and trailing bytes
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned sent;
		int unsigned kind;
		int unsigned n;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 75) begin
				send_frame(pick_byte(), pick_byte(),
					{pick_byte(), pick_byte(), pick_byte(), pick_byte()},
					$urandom_range(99) < 55, 8'($urandom_range(1, 255)));
				sent += 7;
			end else if (kind < 85) begin
				n = $urandom_range(5);
				send_byte(pick_byte(), 1'b1);
				repeat (n) send_byte(pick_byte(), 1'b0);
				sent += n + 1;
			end else if (kind < 93) begin
				n = $urandom_range(1, 4);
				repeat (n) send_byte(pick_byte(), 1'b0);
				sent += n;
			end else begin
				send_frame(pick_byte(), pick_byte(), $urandom, 1'b1, 8'h00);
				n = $urandom_range(1, 3);
				repeat (n) send_byte(pick_byte(), 1'b0);
				sent += 7 + n;
			end
		end
	endtask

	initial begin
		logic [7:0] polys[6];
		logic [7:0] masks[6];
		polys = '{8'h07, 8'h00, 8'hFF, pick_byte(), efcc_pkg::POLY_RESET, pick_byte()};
		masks = '{8'hFF, 8'h00, pick_byte(), 8'h80, pick_byte(), pick_byte()};

		// Hold reset, then release
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_stall_pct = 69;
		test_idle_bytes_before_start();
		test_frame_extremes();
		test_failed_frame();
		test_restart_and_live_config();

		for (int seg = 0; seg < 6; seg++) begin
			write_reg(efcc_pkg::CFG_CRC_POLYNOMIAL, polys[seg]);
			write_reg(efcc_pkg::CFG_LOW_BYTE_MASK, masks[seg]);
			if (seg < 2) begin
				send_idle_pct = 30;
				recv_stall_pct = 69;
			end else if (seg < 4) begin
				send_idle_pct = 69;
				recv_stall_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			test_random_traffic(315);
		end

		// Drain outstanding reports and let the pipeline settle
		req_valid <= 1'b0;
		while (frame_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
